// ===== rtl/core/utf8vd_pkg.sv =====
// utf8vd_pkg: shared types, codes and byte classification for the UTF-8 validating decoder.
// No dependencies. Imported by every module of the decoder.
`default_nettype none
package utf8vd_pkg;

    // report kinds
    localparam logic [2:0] K_CODE = 3'd0;
    localparam logic [2:0] K_SUR  = 3'd1;
    localparam logic [2:0] K_BRK  = 3'd2;
    localparam logic [2:0] K_INV  = 3'd3;
    localparam logic [2:0] K_CTX  = 3'd4;
    localparam logic [2:0] K_TAIL = 3'd5;

    // byte classes
    localparam logic [2:0] CL_T0   = 3'd0;
    localparam logic [2:0] CL_T1   = 3'd1;
    localparam logic [2:0] CL_T2   = 3'd2;
    localparam logic [2:0] CL_T3   = 3'd3;
    localparam logic [2:0] CL_ASC  = 3'd4;
    localparam logic [2:0] CL_HEAD = 3'd5;
    localparam logic [2:0] CL_BAD  = 3'd6;

    // decoder modes
    localparam logic [3:0] M_IDLE   = 4'd0;
    localparam logic [3:0] M_2OF2   = 4'd1;
    localparam logic [3:0] M_2OF3   = 4'd2;
    localparam logic [3:0] M_2OF3E0 = 4'd3;
    localparam logic [3:0] M_2OF3ED = 4'd4;
    localparam logic [3:0] M_2OF4   = 4'd5;
    localparam logic [3:0] M_2OF4F0 = 4'd6;
    localparam logic [3:0] M_2OF4F4 = 4'd7;
    localparam logic [3:0] M_3OF3   = 4'd8;
    localparam logic [3:0] M_3OF3HS = 4'd9;
    localparam logic [3:0] M_3OF3LS = 4'd10;
    localparam logic [3:0] M_3OF4   = 4'd11;
    localparam logic [3:0] M_4OF4   = 4'd12;

    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [2:0]        kind;
        logic signed [2:0] offset;
        logic [2:0]        span_length;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] head_mode;
    } byte_info_t;

    function automatic byte_info_t classify(input logic [7:0] v);
        byte_info_t bi;
        bi.head_mode = M_IDLE;
        bi.cls       = CL_BAD;
        if (v < 8'h80) begin
            bi.cls = CL_ASC;
        end else if (v < 8'hC0) begin
            bi.cls = {1'b0, v[5:4]};
        end else if (v < 8'hC2) begin
            bi.cls = CL_BAD;
        end else if (v < 8'hE0) begin
            bi.cls = CL_HEAD; bi.head_mode = M_2OF2;
        end else if (v == 8'hE0) begin
            bi.cls = CL_HEAD; bi.head_mode = M_2OF3E0;
        end else if (v == 8'hED) begin
            bi.cls = CL_HEAD; bi.head_mode = M_2OF3ED;
        end else if (v < 8'hF0) begin
            bi.cls = CL_HEAD; bi.head_mode = M_2OF3;
        end else if (v == 8'hF0) begin
            bi.cls = CL_HEAD; bi.head_mode = M_2OF4F0;
        end else if (v < 8'hF4) begin
            bi.cls = CL_HEAD; bi.head_mode = M_2OF4;
        end else if (v == 8'hF4) begin
            bi.cls = CL_HEAD; bi.head_mode = M_2OF4F4;
        end
        return bi;
    endfunction

    function automatic res_t make_res(input logic [2:0] kind, input logic [1:0] back,
                                      input logic [2:0] len, input logic last);
        res_t r;
        r.kind        = kind;
        r.offset      = 3'sd0 - $signed({1'b0, back});
        r.span_length = len;
        r.last        = last;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/utf8vd_step.sv =====
// utf8vd_step: one decoder move; byte class plus current mode give next mode and up to two reports.
// Depends on utf8vd_pkg.
`default_nettype none
module utf8vd_step
    import utf8vd_pkg::*;
(
    input  wire logic       func,
    input  wire logic [7:0] data_byte,
    input  wire logic [3:0] mode_cur,
    input  wire logic [1:0] pend_cur,
    output logic [3:0]      mode_nxt,
    output logic [1:0]      pend_nxt,
    output logic [1:0]      res_count,
    output res_t            res0,
    output res_t            res1
);

    logic [3:0] mode_eff;
    logic [1:0] pend_eff;
    byte_info_t bi;
    logic [2:0] pend_len;

    always_comb begin
        mode_eff  = (mode_cur > M_4OF4) ? M_IDLE : mode_cur;
        pend_eff  = (mode_cur > M_4OF4) ? 2'd0 : pend_cur;
        pend_len  = {1'b0, pend_eff};
        bi        = classify(data_byte);
        mode_nxt  = M_IDLE;
        pend_nxt  = 2'd0;
        res_count = 2'd0;
        res0      = '0;
        res1      = '0;
        if (func) begin
            if (pend_eff == 2'd0) begin
                mode_nxt = mode_cur;
                pend_nxt = pend_cur;
            end else begin
                res0      = make_res(K_BRK, pend_eff - 2'd1, pend_len, 1'b1);
                res_count = 2'd1;
            end
        end else if (bi.cls == CL_BAD || bi.cls == CL_ASC) begin
            if (mode_eff == M_IDLE) begin
                res0      = make_res((bi.cls == CL_BAD) ? K_INV : K_CODE, 2'd0, 3'd1, 1'b1);
                res_count = 2'd1;
            end else begin
                res0      = make_res(K_BRK, pend_eff, pend_len, 1'b0);
                res1      = make_res((bi.cls == CL_BAD) ? K_INV : K_CODE, 2'd0, 3'd1, 1'b1);
                res_count = 2'd2;
            end
        end else if (bi.cls == CL_HEAD) begin
            mode_nxt = bi.head_mode;
            pend_nxt = 2'd1;
            if (mode_eff != M_IDLE) begin
                res0      = make_res(K_BRK, pend_eff, pend_len, 1'b1);
                res_count = 2'd1;
            end
        end else begin
            // tail byte
            unique case (mode_eff)
                M_IDLE: begin
                    res0      = make_res(K_TAIL, 2'd0, 3'd1, 1'b1);
                    res_count = 2'd1;
                end
                M_2OF2, M_3OF3, M_4OF4: begin
                    res0      = make_res(K_CODE, pend_eff, pend_len + 3'd1, 1'b1);
                    res_count = 2'd1;
                end
                M_3OF3HS, M_3OF3LS: begin
                    res0      = make_res(K_SUR, 2'd2, 3'd3, 1'b1);
                    res_count = 2'd1;
                end
                M_2OF3: begin
                    mode_nxt = M_3OF3;
                end
                M_2OF3E0: begin
                    if (bi.cls == CL_T0 || bi.cls == CL_T1) begin
                        res0      = make_res(K_CTX, 2'd1, 3'd2, 1'b1);
                        res_count = 2'd1;
                    end else begin
                        mode_nxt = M_3OF3;
                    end
                end
                M_2OF3ED: begin
                    mode_nxt = (bi.cls == CL_T2) ? M_3OF3HS :
                               (bi.cls == CL_T3) ? M_3OF3LS : M_3OF3;
                end
                M_2OF4: begin
                    mode_nxt = M_3OF4;
                end
                M_2OF4F0: begin
                    if (bi.cls == CL_T0) begin
                        res0      = make_res(K_CTX, 2'd1, 3'd2, 1'b1);
                        res_count = 2'd1;
                    end else begin
                        mode_nxt = M_3OF4;
                    end
                end
                M_2OF4F4: begin
                    if (bi.cls != CL_T0) begin
                        res0      = make_res(K_CTX, 2'd1, 3'd2, 1'b1);
                        res_count = 2'd1;
                    end else begin
                        mode_nxt = M_3OF4;
                    end
                end
                default: begin
                    mode_nxt = M_4OF4;
                end
            endcase
            if (res_count == 2'd0) begin
                pend_nxt = pend_eff + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/utf8vd_outq.sv =====
// utf8vd_outq: small result queue; takes zero to two reports per cycle, hands out one per transaction.
// Depends on utf8vd_pkg.
`default_nettype none
module utf8vd_outq
    import utf8vd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [1:0] push_count,
    input  wire res_t       push0,
    input  wire res_t       push1,
    input  wire logic       pop,
    output logic [2:0]      space,
    output logic            head_valid,
    output res_t            head
);

    res_t       entry_reg [QDEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] wr_ptr_p1;

    assign wr_ptr_p1   = wr_ptr_reg + 2'd1;
    assign head_valid  = (count_reg != 3'd0);
    assign head        = entry_reg[rd_ptr_reg];
    assign space       = 3'(QDEPTH) - count_reg + {2'd0, pop};
    assign wr_ptr_next = wr_ptr_reg + push_count;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign count_next  = count_reg + {1'b0, push_count} - {2'd0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            entry_reg[wr_ptr_p1] <= push1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/utf8_validating_decoder.sv =====
// utf8_validating_decoder: top level; input register, decoder state, step logic, result queue.
// Depends on utf8vd_pkg, utf8vd_step, utf8vd_outq.
//
// Usage:
//   Slave channel s_: one byte or an end-of-stream request per transaction.
//     s_tdata[7:0] is the byte, s_tuser is 1 for end of stream (byte ignored).
//   Master channel m_: one span report per transaction, kind on m_tuser,
//     offset and span length on m_tdata, m_tlast on the final report of an input.
//   Latency: with the queue empty, a report passes the input register and then a
//     queue entry before it is valid on m_, and can be taken at the following edge.
//   Throughput: one input per cycle while the queue has room for its reports; the
//     decoder state is updated by one table step per accepted input. Inputs that cause
//     two reports (broken sequence followed by an ASCII or invalid byte) leave as two transactions.
//   A four-entry result queue separates the channels; input keeps flowing while
//     reports wait, and s_tready drops only when the queue cannot take the
//     reports of the held input.
//   Reset (aresetn low, synchronous) empties the queue and the input register and
//     returns the decoder to expecting a head byte with nothing pending.
//   A stalled receiver holds m_ stable; no report is lost or repeated.
`default_nettype none
module utf8_validating_decoder
    import utf8vd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tuser,   // [0] func
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [2:0] offset, [5:3] span_length, [7:6] zero
    output logic [2:0]      m_tuser,   // [2:0] kind
    output logic            m_tlast
);

    logic       in_vld_reg, in_vld_next;
    logic       func_reg;
    logic [7:0] byte_reg;
    logic [3:0] mode_reg;
    logic [1:0] pend_reg;

    logic [3:0] mode_nxt;
    logic [1:0] pend_nxt;
    logic [1:0] res_count;
    res_t       res0, res1;

    logic [2:0] space;
    logic       head_valid;
    res_t       head;
    logic       fire, s_accept, pop;

    utf8vd_step u_step (
        .func      (func_reg),
        .data_byte (byte_reg),
        .mode_cur  (mode_reg),
        .pend_cur  (pend_reg),
        .mode_nxt  (mode_nxt),
        .pend_nxt  (pend_nxt),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    assign pop      = head_valid && m_tready;
    assign fire     = in_vld_reg && (space >= {1'b0, res_count});
    assign s_tready = !in_vld_reg || fire;
    assign s_accept = s_tvalid && s_tready;
    assign in_vld_next = s_accept ? 1'b1 : (fire ? 1'b0 : in_vld_reg);

    utf8vd_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (fire ? res_count : 2'd0),
        .push0      (res0),
        .push1      (res1),
        .pop        (pop),
        .space      (space),
        .head_valid (head_valid),
        .head       (head)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            mode_reg   <= M_IDLE;
            pend_reg   <= 2'd0;
        end else begin
            in_vld_reg <= in_vld_next;
            if (fire) begin
                mode_reg <= mode_nxt;
                pend_reg <= pend_nxt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg <= s_tuser;
            byte_reg <= s_tdata;
        end
    end

    assign m_tvalid = head_valid;
    assign m_tdata  = {2'b00, head.span_length, head.offset};
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

endmodule
`default_nettype wire

// ===== rtl/core/utf8vd_chk.sv =====
// utf8vd_chk: port-level checks of the decoder's result channel, bound to the top level.
// Depends on utf8vd_pkg and utf8_validating_decoder.
`default_nettype none
module utf8vd_chk
    import utf8vd_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [2:0] m_tuser,
    input wire logic       m_tlast
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= K_TAIL && m_tdata[7:6] == 2'b00)
        else $error("bad report kind or padding");

    a_surrogate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == K_SUR |-> m_tlast && m_tdata[5:3] == 3'd3
                                         && m_tdata[2:0] == 3'b110)
        else $error("surrogate report malformed");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == K_INV || m_tuser == K_TAIL) |->
            m_tlast && m_tdata[5:3] == 3'd1 && m_tdata[2:0] == 3'd0)
        else $error("single byte report malformed");

endmodule

bind utf8_validating_decoder utf8vd_chk u_chk (.*);
`default_nettype wire
